/* hdl/tdcc_pkg.sv */
// Package for the tick-driven calendar clock: field types, reset values,
// unit limits and the month length table. No dependencies.
package tdcc_pkg;

    typedef logic [5:0]  sec_t;
    typedef logic [5:0]  min_t;
    typedef logic [4:0]  hour_t;
    typedef logic [4:0]  day_t;
    typedef logic [3:0]  month_t;
    typedef logic [15:0] year_t;
    typedef logic [15:0] tps_t;
    typedef logic [63:0] ticks_t;

    localparam tps_t   TPS_RESET   = 16'd1000;
    localparam sec_t   SEC_MAX     = 6'd59;
    localparam min_t   MIN_MAX     = 6'd59;
    localparam hour_t  HOUR_MAX    = 5'd23;
    localparam month_t MONTH_MAX   = 4'd12;
    localparam day_t   DAY_FIRST   = 5'd1;
    localparam month_t MONTH_FIRST = 4'd1;
    localparam month_t MONTH_FEB   = 4'd2;
    localparam day_t   FEB_DAYS    = 5'd28;
    localparam day_t   FEB_LEAP    = 5'd29;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // Days in a month; codes 0 and 13..15 count as 31-day months.
    function automatic day_t month_len(input month_t month, input year_t year);
        day_t len;
        case (month)
            4'd2:    len = FEB_DAYS;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        if (month == MONTH_FEB && year[1:0] == 2'b00)
        begin
            len = FEB_LEAP;
        end
        return len;
    endfunction

endpackage

/* hdl/tick_driven_calendar_clock_core.sv */
// Tick-driven real-time clock and calendar: prescaler, tick counter and
// second-to-year carry cascade with a registered result. Depends on tdcc_pkg.
//
//  channel  | signals                        | direction | payload
//  ---------+--------------------------------+-----------+-----------------------------
//  cfg      | cfg_valid / cfg_ready          | in        | cfg_data: ticks per second
//  in       | in_valid  / in_ready           | in        | cmd, load_* time fields
//  out      | out_valid / out_ready          | out       | *_now, second_elapsed, total_ticks
//
// One item per cycle while the result is not stalled: the state update and the
// carry cascade are combinational between the accepted item and the result register.
// A result is registered and appears in the cycle after its item is accepted.
// in_ready is high while the result register is empty or being drained in
// the same cycle; a stalled result holds the input side until taken.
// Reset (rst_n low, asynchronous) sets 00:00:00, day 1, month 1, year 0,
// zero ticks and 1000 ticks per second. cfg_ready is always high.
module tick_driven_calendar_clock_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  tdcc_pkg::tps_t         cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   cmd,
    input  tdcc_pkg::sec_t         load_second,
    input  tdcc_pkg::min_t         load_minute,
    input  tdcc_pkg::hour_t        load_hour,
    input  tdcc_pkg::day_t         load_day,
    input  tdcc_pkg::month_t       load_month,
    input  tdcc_pkg::year_t        load_year,
    output logic                   out_valid,
    input  logic                   out_ready,
    output tdcc_pkg::sec_t         second_now,
    output tdcc_pkg::min_t         minute_now,
    output tdcc_pkg::hour_t        hour_now,
    output tdcc_pkg::day_t         day_now,
    output tdcc_pkg::month_t       month_now,
    output tdcc_pkg::year_t        year_now,
    output logic                   second_elapsed,
    output tdcc_pkg::ticks_t       total_ticks
);
    import tdcc_pkg::*;

    // Configuration and calendar state
    tps_t   tps_reg;
    ticks_t tick_total_reg,   tick_total_next;
    tps_t   subsec_reg,       subsec_next;
    sec_t   sec_reg,          sec_next;
    min_t   min_reg,          min_next;
    hour_t  hour_reg,         hour_next;
    day_t   day_reg,          day_next;
    month_t month_reg,        month_next;
    year_t  year_reg,         year_next;
    logic   elapsed_next;

    // Result register
    logic   out_valid_reg;
    sec_t   out_sec_reg;
    min_t   out_min_reg;
    hour_t  out_hour_reg;
    day_t   out_day_reg;
    month_t out_month_reg;
    year_t  out_year_reg;
    logic   out_elapsed_reg;
    ticks_t out_ticks_reg;

    logic          in_accept;
    logic [16:0]   subsec_inc;
    logic          sec_wrap, min_wrap, hour_wrap, day_wrap, month_wrap;
    day_t          cur_month_len;

    assign cfg_ready = 1'b1;
    // Take a new item whenever the result slot is free or drains this cycle.
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    // Carry cascade: each unit wraps at or above its limit.
    assign subsec_inc    = {1'b0, subsec_reg} + 17'd1;
    assign cur_month_len = month_len(month_reg, year_reg);
    assign sec_wrap      = (sec_reg   >= SEC_MAX);
    assign min_wrap      = (min_reg   >= MIN_MAX);
    assign hour_wrap     = (hour_reg  >= HOUR_MAX);
    assign day_wrap      = (day_reg   >= cur_month_len);
    assign month_wrap    = (month_reg >= MONTH_MAX);

    always_comb
    begin
        tick_total_next = tick_total_reg;
        subsec_next     = subsec_reg;
        sec_next        = sec_reg;
        min_next        = min_reg;
        hour_next       = hour_reg;
        day_next        = day_reg;
        month_next      = month_reg;
        year_next       = year_reg;
        elapsed_next    = 1'b0;
        case (cmd)
            CMD_LOAD:
            begin
                // Load the time as given; tick count and prescaler hold.
                sec_next   = load_second;
                min_next   = load_minute;
                hour_next  = load_hour;
                day_next   = load_day;
                month_next = load_month;
                year_next  = load_year;
            end
            default:
            begin
                tick_total_next = tick_total_reg + 64'd1;
                if (subsec_inc >= {1'b0, tps_reg})
                begin
                    subsec_next  = '0;
                    elapsed_next = 1'b1;
                    sec_next     = sec_wrap ? '0 : sec_reg + 6'd1;
                    if (sec_wrap)
                    begin
                        min_next = min_wrap ? '0 : min_reg + 6'd1;
                    end
                    if (sec_wrap && min_wrap)
                    begin
                        hour_next = hour_wrap ? '0 : hour_reg + 5'd1;
                    end
                    if (sec_wrap && min_wrap && hour_wrap)
                    begin
                        day_next = day_wrap ? DAY_FIRST : day_reg + 5'd1;
                    end
                    if (sec_wrap && min_wrap && hour_wrap && day_wrap)
                    begin
                        month_next = month_wrap ? MONTH_FIRST : month_reg + 4'd1;
                    end
                    if (sec_wrap && min_wrap && hour_wrap && day_wrap && month_wrap)
                    begin
                        year_next = year_reg + 16'd1;
                    end
                end
                else
                begin
                    subsec_next = subsec_inc[15:0];
                end
            end
        endcase
    end

    // Control and calendar state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg        <= TPS_RESET;
            tick_total_reg <= '0;
            subsec_reg     <= '0;
            sec_reg        <= '0;
            min_reg        <= '0;
            hour_reg       <= '0;
            day_reg        <= DAY_FIRST;
            month_reg      <= MONTH_FIRST;
            year_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                tps_reg <= cfg_data;
            end
            if (in_accept)
            begin
                tick_total_reg <= tick_total_next;
                subsec_reg     <= subsec_next;
                sec_reg        <= sec_next;
                min_reg        <= min_next;
                hour_reg       <= hour_next;
                day_reg        <= day_next;
                month_reg      <= month_next;
                year_reg       <= year_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: capture the time after each accepted item.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_sec_reg     <= sec_next;
            out_min_reg     <= min_next;
            out_hour_reg    <= hour_next;
            out_day_reg     <= day_next;
            out_month_reg   <= month_next;
            out_year_reg    <= year_next;
            out_elapsed_reg <= elapsed_next;
            out_ticks_reg   <= tick_total_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign second_now     = out_sec_reg;
    assign minute_now     = out_min_reg;
    assign hour_now       = out_hour_reg;
    assign day_now        = out_day_reg;
    assign month_now      = out_month_reg;
    assign year_now       = out_year_reg;
    assign second_elapsed = out_elapsed_reg;
    assign total_ticks    = out_ticks_reg;

`ifndef SYNTHESIS
    a_load_no_second: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && cmd == CMD_LOAD |=> out_valid && !second_elapsed)
        else $error("load item reported an elapsed second");

    a_load_holds_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && cmd == CMD_LOAD |=> tick_total_reg == $past(tick_total_reg))
        else $error("load item changed the tick count");

    a_tick_counts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && cmd == CMD_TICK |=> total_ticks == $past(tick_total_reg) + 64'd1)
        else $error("tick item did not advance the tick count by one");

    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> total_ticks == tick_total_reg && second_now == sec_reg)
        else $error("pending result differs from the clock state");

    a_prescaler_bound: assert property (@(posedge clk) disable iff (!rst_n)
        subsec_reg != 16'hFFFF)
        else $error("prescaler reached its top value");
`endif

endmodule

/* sim/tick_driven_calendar_clock_core_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for tick_driven_calendar_clock_core: directed calendar
// edge cases, then random tick/load traffic under several rates and stall mixes.
// Depends on tdcc_pkg and the core RTL.
module tick_driven_calendar_clock_core_tb;

    import tdcc_pkg::*;

    localparam real CLK_PERIOD     = 12.0;
    localparam int  RESET_CYCLES   = 6;
    localparam int  TIMEOUT_CYCLES = 400000;
    localparam int  DRAIN_CYCLES   = 8;

    // One command item as presented on the input channel.
    typedef struct {
        logic   cmd;
        sec_t   second;
        min_t   minute;
        hour_t  hour;
        day_t   day;
        month_t month;
        year_t  year;
    } clock_cmd_t;

    // One clock reading as returned on the output channel.
    typedef struct {
        sec_t   second;
        min_t   minute;
        hour_t  hour;
        day_t   day;
        month_t month;
        year_t  year;
        logic   elapsed;
        ticks_t ticks;
    } clock_reading_t;

    logic   clk;
    logic   rst_n;
    logic   cfg_valid;
    logic   cfg_ready;
    tps_t   cfg_data;
    logic   in_valid;
    logic   in_ready;
    logic   cmd;
    sec_t   load_second;
    min_t   load_minute;
    hour_t  load_hour;
    day_t   load_day;
    month_t load_month;
    year_t  load_year;
    logic   out_valid;
    logic   out_ready;
    sec_t   second_now;
    min_t   minute_now;
    hour_t  hour_now;
    day_t   day_now;
    month_t month_now;
    year_t  year_now;
    logic   second_elapsed;
    ticks_t total_ticks;

    // Calendar state tracked alongside the block, starting from reset values.
    tps_t   cal_tps    = TPS_RESET;
    ticks_t cal_ticks  = '0;
    tps_t   cal_subsec = '0;
    sec_t   cal_sec    = '0;
    min_t   cal_min    = '0;
    hour_t  cal_hour   = '0;
    day_t   cal_day    = DAY_FIRST;
    month_t cal_month  = MONTH_FIRST;
    year_t  cal_year   = '0;

    clock_cmd_t     pending_cmds[$];
    clock_reading_t expected_readings[$];

    int   sender_idle_pct    = 0;
    int   receiver_stall_pct = 0;
    int   fail_count         = 0;
    int   reading_count      = 0;
    logic in_fire;

    tick_driven_calendar_clock_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .load_second    (load_second),
        .load_minute    (load_minute),
        .load_hour      (load_hour),
        .load_day       (load_day),
        .load_month     (load_month),
        .load_year      (load_year),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .second_now     (second_now),
        .minute_now     (minute_now),
        .hour_now       (hour_now),
        .day_now        (day_now),
        .month_now      (month_now),
        .year_now       (year_now),
        .second_elapsed (second_elapsed),
        .total_ticks    (total_ticks)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2.0) clk = ~clk;
    end

    // Month table; codes outside 1..12 count as 31-day months and
    // February gets its leap day whenever the year is a multiple of four.
    function automatic day_t days_in_month(input month_t mo, input year_t yr);
        case (mo)
            MONTH_FEB:                return (yr[1:0] == 2'b00) ? FEB_LEAP : FEB_DAYS;
            4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
            default:                  return 5'd31;
        endcase
    endfunction

    // Carry one second through the time units. Each unit at or above its
    // limit wraps and passes the carry on; otherwise it counts up and stops.
    function automatic void carry_second();
        if (cal_sec >= SEC_MAX) cal_sec = '0;
        else
        begin
            cal_sec = cal_sec + 1'b1;
            return;
        end
        if (cal_min >= MIN_MAX) cal_min = '0;
        else
        begin
            cal_min = cal_min + 1'b1;
            return;
        end
        if (cal_hour >= HOUR_MAX) cal_hour = '0;
        else
        begin
            cal_hour = cal_hour + 1'b1;
            return;
        end
        if (cal_day >= days_in_month(cal_month, cal_year)) cal_day = DAY_FIRST;
        else
        begin
            cal_day = cal_day + 1'b1;
            return;
        end
        if (cal_month >= MONTH_MAX) cal_month = MONTH_FIRST;
        else
        begin
            cal_month = cal_month + 1'b1;
            return;
        end
        cal_year = cal_year + 1'b1;
    endfunction

    // Apply one accepted command to the tracked state and return the reading
    // the block must produce for it.
    function automatic clock_reading_t apply_cmd(input clock_cmd_t c);
        clock_reading_t r;
        logic [16:0]    next_sub;
        r.elapsed = 1'b0;
        if (c.cmd == CMD_LOAD)
        begin
            // A load takes the fields as given and leaves the tick count alone.
            cal_sec   = c.second;
            cal_min   = c.minute;
            cal_hour  = c.hour;
            cal_day   = c.day;
            cal_month = c.month;
            cal_year  = c.year;
        end
        else
        begin
            cal_ticks = cal_ticks + 1'b1;
            // Compare at 17 bits: a zero rate, or a rate lowered below the
            // running count, ends the second on this tick.
            next_sub = {1'b0, cal_subsec} + 17'd1;
            if (next_sub >= {1'b0, cal_tps})
            begin
                cal_subsec = '0;
                r.elapsed  = 1'b1;
                carry_second();
            end
            else
            begin
                cal_subsec = next_sub[15:0];
            end
        end
        r.second = cal_sec;
        r.minute = cal_min;
        r.hour   = cal_hour;
        r.day    = cal_day;
        r.month  = cal_month;
        r.year   = cal_year;
        r.ticks  = cal_ticks;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("ERROR at %0t, reading %0d: %s", $time, reading_count, msg);
    endtask

    task automatic check_field(input string field, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", field, got, want));
    endtask

    // Check the outgoing reading first, then take the config write and the
    // incoming item, all from values that settled before this edge.
    always @(posedge clk)
    begin : check_and_predict
        clock_reading_t want;
        clock_cmd_t     taken;
        if (rst_n)
        begin
            if (out_valid === 1'b1 && out_ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    report_mismatch("reading with no item waiting");
                end
                else
                begin
                    want = expected_readings.pop_front();
                    check_field("second_now", 64'(second_now), 64'(want.second));
                    check_field("minute_now", 64'(minute_now), 64'(want.minute));
                    check_field("hour_now", 64'(hour_now), 64'(want.hour));
                    check_field("day_now", 64'(day_now), 64'(want.day));
                    check_field("month_now", 64'(month_now), 64'(want.month));
                    check_field("year_now", 64'(year_now), 64'(want.year));
                    check_field("second_elapsed", 64'(second_elapsed), 64'(want.elapsed));
                    check_field("total_ticks", total_ticks, want.ticks);
                end
                reading_count++;
            end
            if (cfg_valid && cfg_ready === 1'b1)
                cal_tps = cfg_data;
            if (in_valid && in_ready === 1'b1)
            begin
                taken.cmd    = cmd;
                taken.second = load_second;
                taken.minute = load_minute;
                taken.hour   = load_hour;
                taken.day    = load_day;
                taken.month  = load_month;
                taken.year   = load_year;
                expected_readings.push_back(apply_cmd(taken));
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_fire <= 1'b0;
        else
            in_fire <= in_valid && (in_ready === 1'b1);
    end

    // Drive the next pending item once the current one is taken; hold it
    // otherwise. Idle gaps are rolled only when the slot is free.
    always @(negedge clk)
    begin : drive_cmds
        clock_cmd_t cur;
        if (rst_n && (!in_valid || in_fire))
        begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                cur = pending_cmds.pop_front();
                in_valid    <= 1'b1;
                cmd         <= cur.cmd;
                load_second <= cur.second;
                load_minute <= cur.minute;
                load_hour   <= cur.hour;
                load_day    <= cur.day;
                load_month  <= cur.month;
                load_year   <= cur.year;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Stall the result channel at the current rate.
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic push_load(input sec_t s, input min_t mi, input hour_t h,
                             input day_t d, input month_t mo, input year_t y);
        clock_cmd_t c;
        c.cmd    = CMD_LOAD;
        c.second = s;
        c.minute = mi;
        c.hour   = h;
        c.day    = d;
        c.month  = mo;
        c.year   = y;
        pending_cmds.push_back(c);
    endtask

    task automatic push_ticks(input int n);
        clock_cmd_t c;
        c.cmd    = CMD_TICK;
        c.second = sec_t'($urandom);
        c.minute = min_t'($urandom);
        c.hour   = hour_t'($urandom);
        c.day    = day_t'($urandom);
        c.month  = month_t'($urandom);
        c.year   = year_t'($urandom);
        for (int i = 0; i < n; i++)
            pending_cmds.push_back(c);
    endtask

    // Mostly loads parked just before a rollover followed by a short burst
    // of ticks; the rest are raw loads of any bit pattern and plain tick runs.
    task automatic push_random_items(input int count);
        int     left;
        int     n;
        int     r;
        sec_t   s;
        min_t   mi;
        hour_t  h;
        day_t   d;
        month_t mo;
        year_t  y;
        left = count;
        while (left > 0)
        begin
            r = $urandom_range(99);
            if (r < 80)
            begin
                s  = sec_t'(($urandom_range(99) < 90) ? $urandom_range(59, 55) :
                            $urandom_range(63));
                r  = $urandom_range(99);
                mi = (r < 60) ? MIN_MAX :
                     min_t'((r < 90) ? $urandom_range(59) : $urandom_range(63));
                r  = $urandom_range(99);
                h  = (r < 60) ? HOUR_MAX :
                     hour_t'((r < 90) ? $urandom_range(23) : $urandom_range(31));
                r  = $urandom_range(99);
                mo = (r < 25) ? MONTH_FEB : (r < 45) ? MONTH_MAX :
                     month_t'((r < 92) ? $urandom_range(12, 1) : $urandom_range(15));
                r  = $urandom_range(99);
                y  = (r < 10) ? 16'hFFFF :
                     year_t'((r < 50) ? ($urandom_range(65535) & 32'hFFFC) :
                             $urandom_range(65535));
                r  = $urandom_range(99);
                d  = (r < 70) ? day_t'(days_in_month(mo, y) - $urandom_range(2)) :
                     day_t'((r < 90) ? $urandom_range(days_in_month(mo, y), 1) :
                            $urandom_range(31));
                push_load(s, mi, h, d, mo, y);
                n = $urandom_range(8, 1);
                push_ticks(n);
                left -= n + 1;
            end
            else if (r < 92)
            begin
                push_load(sec_t'($urandom), min_t'($urandom), hour_t'($urandom),
                          day_t'($urandom), month_t'($urandom), year_t'($urandom));
                left--;
            end
            else
            begin
                n = $urandom_range(12, 1);
                push_ticks(n);
                left -= n;
            end
        end
    endtask

    // Hold the sender until every queued item is taken and every reading is back.
    task automatic wait_idle();
        do @(negedge clk);
        while (pending_cmds.size() != 0 || in_valid || expected_readings.size() != 0);
    endtask

    task automatic write_tps(input tps_t value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk);
        while (cfg_ready !== 1'b1);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input tps_t tps, input int idle_pct, input int stall_pct,
                             input int count, input bit pause_midway);
        write_tps(tps);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        push_random_items(count / 2);
        if (pause_midway)
            wait_idle();
        push_random_items(count - count / 2);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        cmd         = CMD_TICK;
        load_second = '0;
        load_minute = '0;
        load_hour   = '0;
        load_day    = '0;
        load_month  = '0;
        load_year   = '0;
        out_ready   = 1'b1;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Reset rate: two ticks must not complete a second.
        push_ticks(2);
        write_tps(16'd1);
        // Last second of the last year: everything rolls, year wraps to zero.
        push_load(6'd59, 6'd59, 5'd23, 5'd31, 4'd12, 16'hFFFF);
        push_ticks(1);
        // Non-leap February ends on the 28th.
        push_load(6'd58, 6'd59, 5'd23, 5'd28, MONTH_FEB, 16'd2023);
        push_ticks(2);
        // Leap February runs to the 29th, then into March.
        push_load(6'd59, 6'd59, 5'd23, 5'd28, MONTH_FEB, 16'd2024);
        push_ticks(1);
        push_load(6'd59, 6'd59, 5'd23, 5'd29, MONTH_FEB, 16'd2024);
        push_ticks(1);
        // Every unit at or above its limit wraps in one go; month 15 is a 31-day month.
        push_load(6'd63, 6'd63, 5'd31, 5'd31, 4'd15, 16'd100);
        push_ticks(1);
        // Day zero steps to one; month zero steps to one after its 31st.
        push_load(6'd59, 6'd59, 5'd23, 5'd0, 4'd0, 16'd7);
        push_ticks(1);
        push_load(6'd59, 6'd59, 5'd23, 5'd31, 4'd0, 16'd7);
        push_ticks(1);
        // Thirty-day month rolls after the 30th.
        push_load(6'd59, 6'd59, 5'd23, 5'd30, 4'd4, 16'd5);
        push_ticks(1);
        push_load(6'd0, 6'd0, 5'd0, 5'd0, 4'd0, 16'd0);
        push_ticks(1);
        // Zero rate: every tick ends a second.
        write_tps(16'd0);
        push_ticks(2);
        write_tps(16'hFFFF);
        push_ticks(1);

        // Random phases; the large-rate phase leaves a count well above the
        // small rate that follows it, so its first tick ends the second.
        run_phase(16'd1,     0,  0, 165, 1'b0);
        run_phase(16'd2,     47, 0, 165, 1'b0);
        run_phase(16'd0,     0,  47, 165, 1'b0);
        run_phase(16'hFFFF,  7,  7, 165, 1'b0);
        run_phase(16'd3,     0,  0, 165, 1'b0);
        run_phase(16'd1,     47, 0, 165, 1'b1);
        run_phase(16'd60,    0,  47, 165, 1'b0);
        run_phase(16'd1,     7,  7, 165, 1'b0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_readings.size() != 0)
            report_mismatch("readings still expected at end of run");
        if (fail_count == 0)
            $display("tick_driven_calendar_clock_core_tb passed");
        else
            $display("tick_driven_calendar_clock_core_tb failed");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("ERROR: timeout with %0d readings outstanding", expected_readings.size());
        $display("tick_driven_calendar_clock_core_tb failed");
        $finish;
    end

endmodule
